FILE: rtl/skt_pkg.sv
`default_nettype none

package skt_pkg;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_FIND   = 3'd1;
    localparam logic [2:0] OP_READ   = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_SET    = 3'd4;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;
    localparam logic [1:0] STAT_RANGE     = 2'd3;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] key_in;
        logic signed [31:0] value_in;
        logic [5:0]         position;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [5:0]         index_out;
        logic signed [31:0] key_out;
        logic signed [31:0] value_out;
        logic [6:0]         entry_count;
    } t_out_item;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic               ins;
        logic               rm;
        logic               find;
        logic signed [31:0] key;
        logic signed [31:0] value;
        logic [5:0]         position;
    } t_cell_ctl;

    typedef enum logic {
        S_IDLE,
        S_BUSY
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/sorted_key_table_core.sv
// Sorted key/value table, up to CAPACITY entries kept in ascending signed key
// order; an equal key is placed after the keys already present.
// Input channel: i_in_valid / o_in_stall carrying t_in_item (insert, find,
// read, remove, set). Output channel: o_out_valid / i_out_stall carrying
// t_out_item, one result per item, with status and the entry count.
// Entries live in a chain of cells; insert and remove shift the cells from
// the affected place onward by one place. Find and read collect the first hit
// through a registered priority tree of $clog2(CAPACITY) levels.
// A result is registered once the item has passed the leaf registers and
// every level of that tree. The block takes one item at a time; o_in_stall
// is high while an item is in progress.
// A finished result sits in the output register; a new item is accepted
// while it waits. If the receiver still stalls when the next result is
// ready, the block holds that result and keeps o_in_stall high.
// Reset (i_rst_n low, synchronous) empties the table and drops any pending
// result. No clearing pass is needed.
`default_nettype none

module sorted_key_table_core import skt_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire t_in_item  i_in_item,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output t_out_item      o_out_item,
    input  wire logic      i_out_stall
);

    localparam int LVLS = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 6) ? CW : 6;

    t_state            r_state;
    t_state            n_state;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic [LVLS-1:0]   r_wait;
    logic [LVLS-1:0]   n_wait;
    logic              r_set_pend;
    logic              n_set_pend;
    logic [2:0]        r_op;
    logic signed [31:0] r_key;
    logic signed [31:0] r_val;
    logic [1:0]        r_status;
    logic [1:0]        n_status;
    logic              r_out_valid;
    logic              n_out_valid;
    t_out_item         r_out_item;
    t_out_item         n_out_item;
    logic              w_load;
    logic              w_accept;
    logic              w_adv;
    logic              w_full;
    logic              w_range;
    logic              w_out_free;
    t_cell_ctl         w_ctl;

    logic [CAPACITY-1:0] w_live;
    logic [CAPACITY-1:0] w_gt;
    logic [CAPACITY-1:0] w_hit;
    logic [CAPACITY-1:0] w_lgt;
    logic signed [31:0]  w_ckey [CAPACITY];
    logic signed [31:0]  w_cval [CAPACITY];
    logic signed [31:0]  w_lkey [CAPACITY];
    logic signed [31:0]  w_lval [CAPACITY];
    logic signed [31:0]  w_rkey [CAPACITY];
    logic signed [31:0]  w_rval [CAPACITY];

    logic                w_root_hit;
    logic [LVLS-1:0]     w_root_idx;
    logic signed [31:0]  w_root_key;
    logic signed [31:0]  w_root_val;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = (r_count == CW'(CAPACITY));
    assign w_range    = (CMPW'(i_in_item.position) >= CMPW'(r_count));
    assign w_out_free = !r_out_valid || !i_out_stall;

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        assign w_live[gi] = (r_count > CW'(gi));
        if (gi == 0) begin : g_head
            assign w_lgt[gi]  = 1'b0;
            assign w_lkey[gi] = w_ckey[gi];
            assign w_lval[gi] = w_cval[gi];
        end else begin : g_body
            assign w_lgt[gi]  = w_gt[gi-1];
            assign w_lkey[gi] = w_ckey[gi-1];
            assign w_lval[gi] = w_cval[gi-1];
        end
        if (gi == CAPACITY - 1) begin : g_tail
            assign w_rkey[gi] = w_ckey[gi];
            assign w_rval[gi] = w_cval[gi];
        end else begin : g_link
            assign w_rkey[gi] = w_ckey[gi+1];
            assign w_rval[gi] = w_cval[gi+1];
        end
        skt_cell #(.IDX(gi)) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_live      (w_live[gi]),
            .i_left_gt   (w_lgt[gi]),
            .i_left_key  (w_lkey[gi]),
            .i_left_val  (w_lval[gi]),
            .i_right_key (w_rkey[gi]),
            .i_right_val (w_rval[gi]),
            .o_gt        (w_gt[gi]),
            .o_hit       (w_hit[gi]),
            .o_key       (w_ckey[gi]),
            .o_val       (w_cval[gi])
        );
    end

    skt_pick #(.LEAVES(CAPACITY)) u_pick (
        .i_clk (i_clk),
        .i_adv (w_adv),
        .i_hit (w_hit),
        .i_key (w_ckey),
        .i_val (w_cval),
        .o_hit (w_root_hit),
        .o_idx (w_root_idx),
        .o_key (w_root_key),
        .o_val (w_root_val)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_wait      = r_wait;
        n_set_pend  = r_set_pend;
        n_status    = r_status;
        n_out_valid = r_out_valid && i_out_stall;
        w_adv       = 1'b0;
        w_load      = 1'b0;

        w_ctl.ins      = 1'b0;
        w_ctl.rm       = 1'b0;
        w_ctl.find     = (i_in_item.opcode == OP_FIND);
        w_ctl.position = i_in_item.position;
        w_ctl.key      = (r_state == S_IDLE) ? i_in_item.key_in : r_key;
        w_ctl.value    = (r_state == S_IDLE) ? i_in_item.value_in : r_val;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_adv    = 1'b1;
                    n_wait   = LVLS'(LVLS);
                    n_state  = S_BUSY;
                    n_status = STAT_OK;
                    case (i_in_item.opcode)
                        OP_INSERT: begin
                            if (w_full) begin
                                n_status = STAT_FULL;
                            end else begin
                                w_ctl.ins = 1'b1;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        OP_READ: begin
                            if (w_range) n_status = STAT_RANGE;
                        end
                        OP_REMOVE, OP_SET: begin
                            if (w_range) begin
                                n_status = STAT_RANGE;
                            end else begin
                                w_ctl.rm   = 1'b1;
                                n_count    = r_count - CW'(1);
                                n_set_pend = (i_in_item.opcode == OP_SET);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_BUSY: begin
                // second half of set: the removal left a free slot
                if (r_set_pend) begin
                    w_ctl.ins  = 1'b1;
                    n_count    = r_count + CW'(1);
                    n_set_pend = 1'b0;
                end
                if (r_wait != '0) begin
                    w_adv  = 1'b1;
                    n_wait = r_wait - LVLS'(1);
                end else if (w_out_free) begin
                    w_load      = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_item             = '0;
        n_out_item.entry_count = 7'(r_count);
        case (r_op)
            OP_FIND: begin
                if (w_root_hit) begin
                    n_out_item.status    = STAT_OK;
                    n_out_item.index_out = 6'(w_root_idx);
                end else begin
                    n_out_item.status = STAT_NOT_FOUND;
                end
            end
            OP_READ, OP_REMOVE, OP_SET: begin
                n_out_item.status = r_status;
                if (r_status == STAT_OK) begin
                    n_out_item.key_out   = w_root_key;
                    n_out_item.value_out = w_root_val;
                end
            end
            default: begin
                n_out_item.status = r_status;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_wait      <= '0;
            r_set_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_wait      <= n_wait;
            r_set_pend  <= n_set_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_in_item.opcode;
            r_key <= i_in_item.key_in;
            r_val <= i_in_item.value_in;
        end
        r_status <= n_status;
        if (w_load) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

FILE: rtl/skt_cell.sv
`default_nettype none

module skt_cell import skt_pkg::*; #(
    parameter int IDX = 0
) (
    input  wire logic               i_clk,
    input  wire t_cell_ctl          i_ctl,
    input  wire logic               i_live,
    input  wire logic               i_left_gt,
    input  wire logic signed [31:0] i_left_key,
    input  wire logic signed [31:0] i_left_val,
    input  wire logic signed [31:0] i_right_key,
    input  wire logic signed [31:0] i_right_val,
    output logic                    o_gt,
    output logic                    o_hit,
    output logic signed [31:0]      o_key,
    output logic signed [31:0]      o_val
);

    logic signed [31:0] r_key;
    logic signed [31:0] r_val;
    logic signed [31:0] n_key;
    logic signed [31:0] n_val;
    logic               w_gt;
    logic               w_at_or_after;

    assign w_gt          = i_live && (r_key > i_ctl.key);
    assign w_at_or_after = (IDX >= int'(i_ctl.position));

    always_comb begin
        n_key = r_key;
        n_val = r_val;
        if (i_ctl.ins) begin
            // shift right behind the insertion point, take the new item at it
            if (i_left_gt) begin
                n_key = i_left_key;
                n_val = i_left_val;
            end else if (!i_live || w_gt) begin
                n_key = i_ctl.key;
                n_val = i_ctl.value;
            end
        end else if (i_ctl.rm && w_at_or_after) begin
            n_key = i_right_key;
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_val <= n_val;
    end

    assign o_gt  = w_gt;
    assign o_hit = i_ctl.find ? (i_live && (r_key == i_ctl.key))
                              : (IDX == int'(i_ctl.position));
    assign o_key = r_key;
    assign o_val = r_val;

endmodule

`default_nettype wire

FILE: rtl/skt_pick.sv
`default_nettype none

module skt_pick #(
    parameter int LEAVES = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_adv,
    input  wire logic [LEAVES-1:0]  i_hit,
    input  wire logic signed [31:0] i_key [LEAVES],
    input  wire logic signed [31:0] i_val [LEAVES],
    output logic                    o_hit,
    output logic [$clog2(LEAVES)-1:0] o_idx,
    output logic signed [31:0]      o_key,
    output logic signed [31:0]      o_val
);

    localparam int LVLS = $clog2(LEAVES);
    localparam int P    = 1 << LVLS;

    // heap order: node 1 is the root, leaves sit at P .. 2P-1
    logic               w_hit [1:2*P-1];
    logic [LVLS-1:0]    w_idx [1:2*P-1];
    logic signed [31:0] w_key [1:2*P-1];
    logic signed [31:0] w_val [1:2*P-1];

    for (genvar gn = P; gn < 2*P; gn++) begin : g_leaf
        assign w_idx[gn] = LVLS'(gn - P);
        if (gn - P < LEAVES) begin : g_used
            logic               r_hit;
            logic signed [31:0] r_key;
            logic signed [31:0] r_val;
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_hit <= i_hit[gn-P];
                    r_key <= i_key[gn-P];
                    r_val <= i_val[gn-P];
                end
            end
            assign w_hit[gn] = r_hit;
            assign w_key[gn] = r_key;
            assign w_val[gn] = r_val;
        end else begin : g_pad
            assign w_hit[gn] = 1'b0;
            assign w_key[gn] = '0;
            assign w_val[gn] = '0;
        end
    end

    for (genvar gn = 1; gn < P; gn++) begin : g_node
        logic               r_hit;
        logic [LVLS-1:0]    r_idx;
        logic signed [31:0] r_key;
        logic signed [31:0] r_val;
        // first hit wins: prefer the lower half
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_hit <= w_hit[2*gn] || w_hit[2*gn+1];
                if (w_hit[2*gn]) begin
                    r_idx <= w_idx[2*gn];
                    r_key <= w_key[2*gn];
                    r_val <= w_val[2*gn];
                end else begin
                    r_idx <= w_idx[2*gn+1];
                    r_key <= w_key[2*gn+1];
                    r_val <= w_val[2*gn+1];
                end
            end
        end
        assign w_hit[gn] = r_hit;
        assign w_idx[gn] = r_idx;
        assign w_key[gn] = r_key;
        assign w_val[gn] = r_val;
    end

    assign o_hit = w_hit[1];
    assign o_idx = w_idx[1];
    assign o_key = w_key[1];
    assign o_val = w_val[1];

endmodule

`default_nettype wire

FILE: rtl/skt_chk.sv
`default_nettype none

module skt_chk import skt_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire t_in_item  i_in_item,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire t_out_item o_out_item,
    input wire logic      i_out_stall
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("item accepted while another is in progress");

    a_full_count: assert property (@(posedge i_clk)
        o_out_valid && (o_out_item.status == STAT_FULL)
        |-> o_out_item.entry_count == 7'(CAPACITY))
        else $error("table full reported below capacity");

    a_fail_zero: assert property (@(posedge i_clk)
        o_out_valid && (o_out_item.status != STAT_OK)
        |-> (o_out_item.index_out == '0) && (o_out_item.key_out == '0)
            && (o_out_item.value_out == '0))
        else $error("failed item carries data");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind sorted_key_table_core skt_chk #(.CAPACITY(CAPACITY)) u_skt_chk (.*);

`default_nettype wire
